>>> rtl/csgd_pkg.sv
package csgd_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_START_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_START_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_COEFF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK        = 3'd5;

    // Divider step counts: pass_count * 2^32 has 64 bits, 2^76 has 77
    localparam logic [6:0] DIV1_LAST_BIT = 7'd63;
    localparam logic [6:0] DIV2_LAST_BIT = 7'd76;
    localparam logic [6:0] SQRT_LAST_PAIR = 7'd30;

    typedef struct packed {
        logic signed [31:0] grad_re;
        logic signed [31:0] grad_im;
        logic signed [31:0] par_re;
        logic signed [31:0] par_im;
        logic               last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_par_re;
        logic signed [31:0] new_par_im;
        logic               pass_end;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] rate_start_re;
        logic signed [31:0] rate_start_im;
        logic [30:0]        decay_scale;
        logic               decay_enable;
        logic [30:0]        l2_coefficient;
        logic [30:0]        shrink_factor;
    } t_cfg;

    // Commands from controller to datapath
    typedef struct packed {
        logic       accept;
        logic       div_step;
        logic       div_first;
        logic       div_y;
        logic       sq_init;
        logic       sq_step;
        logic       scale_mul;
        logic       scale_wr;
        logic       mul0;
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       write;
        logic [6:0] cnt;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic decay_go;
        logic out_busy;
    } t_stat;

    // Round half up at bit 30, floor shift
    function automatic logic signed [36:0] rnd30(input logic signed [66:0] v);
        logic signed [66:0] s;
        s = v + 67'sd536870912;
        return s[66:30];
    endfunction

    // Saturate to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Saturate to +-(2^31-1)
    function automatic logic signed [31:0] symsat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483647) begin
            return 32'sh80000001;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

>>> rtl/csgd_ctrl.sv
module csgd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  csgd_pkg::t_stat i_stat,
    output csgd_pkg::t_cmd  o_cmd
);
    import csgd_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DIV1   = 13'b0000000000010,
        S_DIVY   = 13'b0000000000100,
        S_DIV2   = 13'b0000000001000,
        S_SQINIT = 13'b0000000010000,
        S_SQRT   = 13'b0000000100000,
        S_SCALEM = 13'b0000001000000,
        S_SCALEW = 13'b0000010000000,
        S_MUL0   = 13'b0000100000000,
        S_MUL1   = 13'b0001000000000,
        S_MUL2   = 13'b0010000000000,
        S_MUL3   = 13'b0100000000000,
        S_WRITE  = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence one item
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.decay_go) begin
                        n_state = S_DIV1;
                        n_cnt   = DIV1_LAST_BIT;
                    end else begin
                        n_state = S_MUL0;
                    end
                end
            end
            S_DIV1: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = 1'b1;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.div_y = 1'b1;
                n_state = S_DIV2;
                n_cnt   = DIV2_LAST_BIT;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_state = S_SQINIT;
                end
            end
            S_SQINIT: begin
                o_cmd.sq_init = 1'b1;
                n_state = S_SQRT;
                n_cnt   = SQRT_LAST_PAIR;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_state = S_SCALEM;
                end
            end
            S_SCALEM: begin
                o_cmd.scale_mul = 1'b1;
                n_state = S_SCALEW;
            end
            S_SCALEW: begin
                o_cmd.scale_wr = 1'b1;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // Hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.write = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/csgd_datapath.sv
module csgd_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csgd_pkg::t_cfg      i_cfg,
    input  csgd_pkg::t_cmd      i_cmd,
    output csgd_pkg::t_stat     o_stat,
    input  csgd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csgd_pkg::t_out_item o_out_data
);
    import csgd_pkg::*;

    t_in_item           r_in;
    logic signed [31:0] r_rate_re, r_rate_im;
    logic               r_rate_loaded;
    logic [31:0]        r_pass_count;
    logic               r_at_start;

    // Divider and square root state
    logic [64:0] r_rem, r_dvs;
    logic [63:0] r_quo;
    logic [61:0] r_rad;
    logic [32:0] r_sqrem;
    logic [30:0] r_root;

    // Product registers
    logic signed [65:0] r_pa0, r_pa1, r_pk0, r_pk1, r_pc0, r_pc1;
    logic signed [31:0] r_ar, r_ai;

    logic      r_out_valid;
    t_out_item r_out;

    logic               dbit;
    logic [65:0]        dtrial;
    logic [65:0]        ddiff;
    logic               dge;
    logic [34:0]        st, strial, sdiff;
    logic               sge;
    logic signed [32:0] k_coef;
    logic signed [32:0] op_a0, op_b0, op_a1, op_b1;
    logic signed [65:0] m0, m1;
    logic signed [36:0] l2r_re, l2r_im, t1_re, t1_im, t2_re, t2_im;
    logic [30:0]        ds_eff;

    assign ds_eff = (i_cfg.decay_scale == 31'd0) ? 31'd1 : i_cfg.decay_scale;

    // Restoring divider step, one quotient bit a cycle
    always_comb begin
        if (i_cmd.div_first) begin
            dbit = i_cmd.cnt[5] & r_pass_count[i_cmd.cnt[4:0]];
        end else begin
            dbit = (i_cmd.cnt == DIV2_LAST_BIT);
        end
        dtrial = {r_rem, dbit};
        dge    = (dtrial >= {1'b0, r_dvs});
        ddiff  = dtrial - {1'b0, r_dvs};
    end

    // Integer square root step, one root bit a cycle
    always_comb begin
        st     = {r_sqrem, r_rad[61:60]};
        strial = {2'b00, r_root, 2'b01};
        sge    = (st >= strial);
        sdiff  = st - strial;
    end

    // Shared multiplier operands
    assign k_coef = 33'sd1073741824 - $signed({2'b00, i_cfg.shrink_factor});

    always_comb begin
        op_a0 = '0;
        op_b0 = '0;
        op_a1 = '0;
        op_b1 = '0;
        if (i_cmd.scale_mul) begin
            op_a0 = 33'(r_rate_re);
            op_b0 = $signed({2'b00, r_root});
            op_a1 = 33'(r_rate_im);
            op_b1 = $signed({2'b00, r_root});
        end else if (i_cmd.mul0) begin
            op_a0 = $signed({2'b00, i_cfg.l2_coefficient});
            op_b0 = 33'(r_in.par_re);
            op_a1 = $signed({2'b00, i_cfg.l2_coefficient});
            op_b1 = 33'(r_in.par_im);
        end else if (i_cmd.mul1) begin
            op_a0 = k_coef;
            op_b0 = 33'(r_in.par_re);
            op_a1 = k_coef;
            op_b1 = 33'(r_in.par_im);
        end else if (i_cmd.mul2) begin
            op_a0 = 33'(r_ar);
            op_b0 = 33'(r_rate_re);
            op_a1 = 33'(r_ai);
            op_b1 = 33'(r_rate_im);
        end else if (i_cmd.mul3) begin
            op_a0 = 33'(r_ar);
            op_b0 = 33'(r_rate_im);
            op_a1 = 33'(r_ai);
            op_b1 = 33'(r_rate_re);
        end
    end

    assign m0 = op_a0 * op_b0;
    assign m1 = op_a1 * op_b1;

    // Rounding of the registered products
    assign l2r_re = rnd30(67'(r_pa0));
    assign l2r_im = rnd30(67'(r_pa1));
    assign t1_re  = rnd30(67'(r_pk0));
    assign t1_im  = rnd30(67'(r_pk1));
    assign t2_re  = rnd30(67'(r_pa0) - 67'(r_pa1));
    assign t2_im  = rnd30(67'(r_pc0) + 67'(r_pc1));

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in  <= i_in_data;
            r_rem <= '0;
            r_quo <= '0;
            r_dvs <= {34'd0, ds_eff};
        end
        if (i_cmd.div_step) begin
            r_rem <= dge ? ddiff[64:0] : dtrial[64:0];
            r_quo <= {r_quo[62:0], dge};
        end
        if (i_cmd.div_y) begin
            r_dvs <= {1'b0, r_quo} + 65'd65536;
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_cmd.sq_init) begin
            r_rad   <= {1'b0, r_quo[60:0]};
            r_sqrem <= '0;
            r_root  <= '0;
        end
        if (i_cmd.sq_step) begin
            r_rad   <= {r_rad[59:0], 2'b00};
            r_sqrem <= sge ? sdiff[32:0] : st[32:0];
            r_root  <= {r_root[29:0], sge};
        end
        if (i_cmd.scale_mul || i_cmd.mul0 || i_cmd.mul2) begin
            r_pa0 <= m0;
            r_pa1 <= m1;
        end
        if (i_cmd.mul1) begin
            r_pk0 <= m0;
            r_pk1 <= m1;
            r_ar  <= symsat32(38'(r_in.grad_re) + 38'(l2r_re));
            r_ai  <= symsat32(38'(r_in.grad_im) + 38'(l2r_im));
        end
        if (i_cmd.mul3) begin
            r_pc0 <= m0;
            r_pc1 <= m1;
        end
        if (i_cmd.write) begin
            r_out.new_par_re <= sat32(38'(t1_re) - 38'(t2_re));
            r_out.new_par_im <= sat32(38'(t1_im) - 38'(t2_im));
            r_out.pass_end   <= r_in.last_element;
        end
    end

    // Kept state: rate, pass counter, pass start flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_re     <= '0;
            r_rate_im     <= '0;
            r_rate_loaded <= 1'b0;
            r_pass_count  <= '0;
            r_at_start    <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_at_start <= 1'b0;
                if (!r_rate_loaded) begin
                    r_rate_re     <= i_cfg.rate_start_re;
                    r_rate_im     <= i_cfg.rate_start_im;
                    r_rate_loaded <= 1'b1;
                end
            end
            // The rounded scaled rate never leaves the 32-bit range
            if (i_cmd.scale_wr) begin
                r_rate_re <= l2r_re[31:0];
                r_rate_im <= l2r_im[31:0];
            end
            if (i_cmd.write) begin
                r_out_valid <= 1'b1;
                if (r_in.last_element) begin
                    r_at_start <= 1'b1;
                    if (r_pass_count != 32'hFFFFFFFF) begin
                        r_pass_count <= r_pass_count + 32'd1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.decay_go = r_at_start & i_cfg.decay_enable;
    assign o_stat.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

>>> rtl/complex_sgd_update_unit.sv
// Complex SGD update unit.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one complex
// gradient/parameter pair in Q16.16 with a last_element flag closing a pass.
// Output channel (o_out_valid / i_out_ready / o_out_data) gives one updated
// parameter per item, saturated Q16.16, with pass_end copied from the flag.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data).
// Items are taken one at a time (accept, four shared-multiplier steps,
// output write); the two multipliers are reused for every product.
// The first item of a pass with decay enabled first runs a 64-step
// and a 77-step bit-serial divide, a 31-step square root and a rate
// rescale, the first three on the one-bit-per-cycle divider and root units.
// o_out_valid is registered from the output write, which follows the
// multiplier steps and, at a decaying pass start, the decay steps above.
// Reset (synchronous, i_rst_n low) restores the register defaults, clears
// the kept rate and pass counter and marks a pass start.
// A stalled receiver holds the result in the output register; the next item
// may be accepted meanwhile and waits in its last step until the register frees.
module complex_sgd_update_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  csgd_pkg::t_in_item        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output csgd_pkg::t_out_item       o_out_data,
    input  logic                      i_cfg_we,
    input  logic [csgd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]               i_cfg_data
);
    import csgd_pkg::*;

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_start_re  <= 32'sd10737418;
            r_cfg.rate_start_im  <= '0;
            r_cfg.decay_scale    <= 31'd65536;
            r_cfg.decay_enable   <= 1'b1;
            r_cfg.l2_coefficient <= '0;
            r_cfg.shrink_factor  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE_START_RE: r_cfg.rate_start_re  <= i_cfg_data;
                CFG_RATE_START_IM: r_cfg.rate_start_im  <= i_cfg_data;
                CFG_DECAY_SCALE:   r_cfg.decay_scale    <= i_cfg_data[30:0];
                CFG_DECAY_ENABLE:  r_cfg.decay_enable   <= i_cfg_data[0];
                CFG_L2_COEFF:      r_cfg.l2_coefficient <= i_cfg_data[30:0];
                CFG_SHRINK:        r_cfg.shrink_factor  <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    csgd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    csgd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Accepted item blocks further input until its write
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // Output valid only rises from a write command
    a_valid_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.write))
        else $error("output valid without write");

    // A write always presents a result
    a_write_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.write |=> o_out_valid)
        else $error("write did not set output valid");

    // Never write over a result still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.write |-> !(o_out_valid && !i_out_ready))
        else $error("result overwritten");

endmodule
